>>> sv/owtr_pkg.sv
// shared types, register map and constants for the one-wire temperature reader
package owtr_pkg;

	localparam int CfgAddrWidth = 5;
	localparam int CfgDataWidth = 32;
	localparam int TickWidth    = 20;

	// register indexes, byte address is 4 * index
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_RESET_LOW         = 3'd0;
	localparam reg_idx_t REG_PRESENCE_SAMPLE   = 3'd1;
	localparam reg_idx_t REG_PRESENCE_RECOVERY = 3'd2;
	localparam reg_idx_t REG_SHORT_SLOT        = 3'd3;
	localparam reg_idx_t REG_LONG_SLOT         = 3'd4;
	localparam reg_idx_t REG_READ_SAMPLE       = 3'd5;
	localparam reg_idx_t REG_READ_TAIL         = 3'd6;
	localparam reg_idx_t REG_CONVERT_WAIT      = 3'd7;

	// reset values of the timing registers, in microsecond ticks
	localparam logic [15:0] RST_RESET_LOW         = 16'd2000;
	localparam logic [7:0]  RST_PRESENCE_SAMPLE   = 8'd70;
	localparam logic [15:0] RST_PRESENCE_RECOVERY = 16'd500;
	localparam logic [3:0]  RST_SHORT_SLOT        = 4'd5;
	localparam logic [7:0]  RST_LONG_SLOT         = 8'd70;
	localparam logic [3:0]  RST_READ_SAMPLE       = 4'd10;
	localparam logic [7:0]  RST_READ_TAIL         = 8'd60;
	localparam logic [19:0] RST_CONVERT_WAIT      = 20'd1000000;

	// bus command bytes
	localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
	localparam logic [7:0] CMD_CONVERT    = 8'h44;
	localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

	// steps of the read sequence
	typedef logic [2:0] step_t;
	localparam step_t STEP_RESET1     = 3'd0;
	localparam step_t STEP_SKIP_ROM1  = 3'd0;
	localparam step_t STEP_CONVERT    = 3'd1;
	localparam step_t STEP_CONV_WAIT  = 3'd2;
	localparam step_t STEP_RESET2     = 3'd3;
	localparam step_t STEP_SKIP_ROM2  = 3'd4;
	localparam step_t STEP_READ_CMD   = 3'd5;
	localparam step_t STEP_READ_LO    = 3'd6;
	localparam step_t STEP_READ_HI    = 3'd7;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_R_PRE,
		PH_R_LOW,
		PH_R_WAIT,
		PH_R_REC,
		PH_W_LOW,
		PH_W_REL,
		PH_CONV,
		PH_RD_LOW,
		PH_RD_REL,
		PH_RD_TAIL
	} phase_t;

	typedef struct packed {
		logic [15:0] reset_low;
		logic [7:0]  presence_sample;
		logic [15:0] presence_recovery;
		logic [3:0]  short_slot;
		logic [7:0]  long_slot;
		logic [3:0]  read_sample;
		logic [7:0]  read_tail;
		logic [19:0] convert_wait;
	} cfg_t;

	typedef struct packed {
		logic               drive_low;
		logic               busy;
		logic               done;
		logic               missing;
		logic signed [15:0] temperature;
	} result_t;

	// byte written at each write step of the sequence
	function automatic logic [7:0] op_cmd(input step_t k);
		logic [7:0] c;
		unique case (k)
			STEP_SKIP_ROM1: c = CMD_SKIP_ROM;
			STEP_CONVERT:   c = CMD_CONVERT;
			STEP_SKIP_ROM2: c = CMD_SKIP_ROM;
			STEP_READ_CMD:  c = CMD_READ_SCRATCH;
			default:        c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> sv/owtr_regs.sv
// timing register file behind the apb-style configuration port
module owtr_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [owtr_pkg::CfgAddrWidth-1:0]   paddr,
	input  logic [owtr_pkg::CfgDataWidth-1:0]   pwdata,
	output logic [owtr_pkg::CfgDataWidth-1:0]   prdata,
	output logic                                pready,
	output owtr_pkg::cfg_t                      cfg
);

	owtr_pkg::cfg_t      cfg_q;
	owtr_pkg::reg_idx_t  idx;
	logic                wr_en;

	assign idx    = paddr[owtr_pkg::CfgAddrWidth-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low         <= owtr_pkg::RST_RESET_LOW;
			cfg_q.presence_sample   <= owtr_pkg::RST_PRESENCE_SAMPLE;
			cfg_q.presence_recovery <= owtr_pkg::RST_PRESENCE_RECOVERY;
			cfg_q.short_slot        <= owtr_pkg::RST_SHORT_SLOT;
			cfg_q.long_slot         <= owtr_pkg::RST_LONG_SLOT;
			cfg_q.read_sample       <= owtr_pkg::RST_READ_SAMPLE;
			cfg_q.read_tail         <= owtr_pkg::RST_READ_TAIL;
			cfg_q.convert_wait      <= owtr_pkg::RST_CONVERT_WAIT;
		end else if (wr_en) begin
			unique case (idx)
				owtr_pkg::REG_RESET_LOW:         cfg_q.reset_low         <= pwdata[15:0];
				owtr_pkg::REG_PRESENCE_SAMPLE:   cfg_q.presence_sample   <= pwdata[7:0];
				owtr_pkg::REG_PRESENCE_RECOVERY: cfg_q.presence_recovery <= pwdata[15:0];
				owtr_pkg::REG_SHORT_SLOT:        cfg_q.short_slot        <= pwdata[3:0];
				owtr_pkg::REG_LONG_SLOT:         cfg_q.long_slot         <= pwdata[7:0];
				owtr_pkg::REG_READ_SAMPLE:       cfg_q.read_sample       <= pwdata[3:0];
				owtr_pkg::REG_READ_TAIL:         cfg_q.read_tail         <= pwdata[7:0];
				owtr_pkg::REG_CONVERT_WAIT:      cfg_q.convert_wait      <= pwdata[19:0];
				default:                         cfg_q.convert_wait      <= cfg_q.convert_wait;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			owtr_pkg::REG_RESET_LOW:         prdata = 32'(cfg_q.reset_low);
			owtr_pkg::REG_PRESENCE_SAMPLE:   prdata = 32'(cfg_q.presence_sample);
			owtr_pkg::REG_PRESENCE_RECOVERY: prdata = 32'(cfg_q.presence_recovery);
			owtr_pkg::REG_SHORT_SLOT:        prdata = 32'(cfg_q.short_slot);
			owtr_pkg::REG_LONG_SLOT:         prdata = 32'(cfg_q.long_slot);
			owtr_pkg::REG_READ_SAMPLE:       prdata = 32'(cfg_q.read_sample);
			owtr_pkg::REG_READ_TAIL:         prdata = 32'(cfg_q.read_tail);
			owtr_pkg::REG_CONVERT_WAIT:      prdata = 32'(cfg_q.convert_wait);
			default:                         prdata = '0;
		endcase
	end

endmodule

>>> sv/owtr_core.sv
// bus sequencer: phase state and the per-tick next-state logic
module owtr_core (
	input  logic                clk,
	input  logic                arst_n,
	input  owtr_pkg::cfg_t      cfg,
	input  logic                step_en,
	input  logic                start,
	input  logic                line,
	output owtr_pkg::result_t   res
);

	// enough to walk the longest run of zero-length phases after one phase ends
	localparam int SkipMax = 6;

	typedef struct packed {
		owtr_pkg::phase_t                   phase;
		logic [owtr_pkg::TickWidth-1:0]     tick;
		logic [2:0]                         bit_idx;
		owtr_pkg::step_t                    step;
		logic [7:0]                         shift;
		logic [7:0]                         low_byte;
		logic [15:0]                        temp;
		logic                               missing;
		logic                               fin;
	} seq_t;

	typedef struct packed {
		logic rlow;
		logic rec;
		logic short_s;
		logic long_s;
		logic conv;
		logic tail;
	} zero_t;

	function automatic seq_t finish(input seq_t s);
		seq_t r;
		r         = s;
		r.fin     = 1'b1;
		r.step    = owtr_pkg::STEP_RESET1;
		r.bit_idx = '0;
		r.phase   = owtr_pkg::PH_IDLE;
		return r;
	endfunction

	function automatic seq_t start_op(input seq_t s, input owtr_pkg::step_t k);
		seq_t r;
		r         = s;
		r.step    = k;
		r.bit_idx = '0;
		unique case (k)
			owtr_pkg::STEP_CONV_WAIT: r.phase = owtr_pkg::PH_CONV;
			owtr_pkg::STEP_RESET2:    r.phase = owtr_pkg::PH_R_PRE;
			owtr_pkg::STEP_READ_LO, owtr_pkg::STEP_READ_HI: begin
				r.shift = '0;
				r.phase = owtr_pkg::PH_RD_LOW;
			end
			default: begin
				r.shift = owtr_pkg::op_cmd(k);
				r.phase = owtr_pkg::PH_W_LOW;
			end
		endcase
		return r;
	endfunction

	// what happens when a phase ends, line is the level on its last tick
	function automatic seq_t follow(input seq_t s, input logic ln);
		seq_t r;
		r = s;
		unique case (s.phase)
			owtr_pkg::PH_R_PRE: r.phase = owtr_pkg::PH_R_LOW;
			owtr_pkg::PH_R_LOW: r.phase = owtr_pkg::PH_R_WAIT;
			owtr_pkg::PH_R_WAIT: begin
				if (s.step == owtr_pkg::STEP_RESET1)
					r.missing = ln;
				r.phase = owtr_pkg::PH_R_REC;
			end
			owtr_pkg::PH_R_REC: begin
				if (s.step != owtr_pkg::STEP_RESET1)
					r = start_op(s, owtr_pkg::STEP_SKIP_ROM2);
				else if (s.missing)
					r = finish(s);
				else
					r = start_op(s, owtr_pkg::STEP_SKIP_ROM1);
			end
			owtr_pkg::PH_W_LOW: r.phase = owtr_pkg::PH_W_REL;
			owtr_pkg::PH_W_REL: begin
				r.shift = {1'b0, s.shift[7:1]};
				if (s.bit_idx == owtr_pkg::LAST_BIT) begin
					r = start_op(r, s.step + 3'd1);
				end else begin
					r.bit_idx = s.bit_idx + 3'd1;
					r.phase   = owtr_pkg::PH_W_LOW;
				end
			end
			owtr_pkg::PH_CONV:   r = start_op(s, owtr_pkg::STEP_RESET2);
			owtr_pkg::PH_RD_LOW: r.phase = owtr_pkg::PH_RD_REL;
			owtr_pkg::PH_RD_REL: begin
				r.shift = {ln, s.shift[7:1]};
				r.phase = owtr_pkg::PH_RD_TAIL;
			end
			owtr_pkg::PH_RD_TAIL: begin
				if (s.bit_idx != owtr_pkg::LAST_BIT) begin
					r.bit_idx = s.bit_idx + 3'd1;
					r.phase   = owtr_pkg::PH_RD_LOW;
				end else if (s.step == owtr_pkg::STEP_READ_LO) begin
					r.low_byte = s.shift;
					r = start_op(r, owtr_pkg::STEP_READ_HI);
				end else begin
					r.temp = {s.shift, s.low_byte};
					r = finish(r);
				end
			end
			default: r = finish(s);
		endcase
		return r;
	endfunction

	// sampling phases never count as zero length
	function automatic logic dur_zero(input seq_t s, input zero_t z);
		logic d;
		unique case (s.phase)
			owtr_pkg::PH_R_PRE:   d = z.short_s;
			owtr_pkg::PH_R_LOW:   d = z.rlow;
			owtr_pkg::PH_R_REC:   d = z.rec;
			owtr_pkg::PH_W_LOW:   d = s.shift[0] ? z.short_s : z.long_s;
			owtr_pkg::PH_W_REL:   d = s.shift[0] ? z.long_s : z.short_s;
			owtr_pkg::PH_CONV:    d = z.conv;
			owtr_pkg::PH_RD_LOW:  d = z.short_s;
			owtr_pkg::PH_RD_TAIL: d = z.tail;
			default:              d = 1'b0;
		endcase
		return d;
	endfunction

	// with both slot times zero a whole write byte passes in no time
	function automatic seq_t skip(input seq_t s, input zero_t z);
		seq_t r;
		if ((s.phase == owtr_pkg::PH_W_LOW || s.phase == owtr_pkg::PH_W_REL) &&
				z.short_s && z.long_s) begin
			r       = s;
			r.shift = '0;
			r       = start_op(r, s.step + 3'd1);
		end else begin
			r = follow(s, 1'b0);
		end
		return r;
	endfunction

	function automatic logic [owtr_pkg::TickWidth-1:0] duration(input seq_t s,
			input owtr_pkg::cfg_t c);
		logic [owtr_pkg::TickWidth-1:0] d;
		unique case (s.phase)
			owtr_pkg::PH_R_PRE:   d = 20'(c.short_slot);
			owtr_pkg::PH_R_LOW:   d = 20'(c.reset_low);
			owtr_pkg::PH_R_WAIT:
				d = (c.presence_sample == '0) ? 20'd1 : 20'(c.presence_sample);
			owtr_pkg::PH_R_REC:   d = 20'(c.presence_recovery);
			owtr_pkg::PH_W_LOW:
				d = s.shift[0] ? 20'(c.short_slot) : 20'(c.long_slot);
			owtr_pkg::PH_W_REL:
				d = s.shift[0] ? 20'(c.long_slot) : 20'(c.short_slot);
			owtr_pkg::PH_CONV:    d = c.convert_wait;
			owtr_pkg::PH_RD_LOW:  d = 20'(c.short_slot);
			owtr_pkg::PH_RD_REL:
				d = (c.read_sample == '0) ? 20'd1 : 20'(c.read_sample);
			owtr_pkg::PH_RD_TAIL: d = 20'(c.read_tail);
			default:              d = 20'd1;
		endcase
		return d;
	endfunction

	seq_t               seq_q;
	seq_t               cur;
	seq_t               nxt;
	zero_t              zf;
	owtr_pkg::phase_t   head_phase;

	always_comb begin
		zf.rlow    = (cfg.reset_low == '0);
		zf.rec     = (cfg.presence_recovery == '0);
		zf.short_s = (cfg.short_slot == '0);
		zf.long_s  = (cfg.long_slot == '0);
		zf.conv    = (cfg.convert_wait == '0);
		zf.tail    = (cfg.read_tail == '0);
	end

	always_comb begin
		cur     = seq_q;
		cur.fin = 1'b0;
		if (cur.phase == owtr_pkg::PH_IDLE && start) begin
			cur.missing = 1'b0;
			cur.step    = owtr_pkg::STEP_RESET1;
			cur.bit_idx = '0;
			cur.tick    = '0;
			// the pre-release and low part of the reset pulse may be zero length
			if (!zf.short_s)
				cur.phase = owtr_pkg::PH_R_PRE;
			else if (!zf.rlow)
				cur.phase = owtr_pkg::PH_R_LOW;
			else
				cur.phase = owtr_pkg::PH_R_WAIT;
		end
		head_phase = cur.phase;
		nxt        = cur;
		if (cur.phase != owtr_pkg::PH_IDLE) begin
			nxt.tick = cur.tick + 20'd1;
			if (nxt.tick >= duration(cur, cfg)) begin
				nxt = follow(nxt, line);
				for (int i = 0; i < SkipMax; i++) begin
					if (nxt.phase != owtr_pkg::PH_IDLE && dur_zero(nxt, zf))
						nxt = skip(nxt, zf);
				end
				nxt.tick = '0;
			end
		end
	end

	always_comb begin
		res.drive_low   = (head_phase == owtr_pkg::PH_R_LOW) ||
		                  (head_phase == owtr_pkg::PH_W_LOW) ||
		                  (head_phase == owtr_pkg::PH_RD_LOW);
		res.busy        = (head_phase != owtr_pkg::PH_IDLE);
		res.done        = nxt.fin;
		res.missing     = nxt.missing;
		res.temperature = nxt.temp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '{phase: owtr_pkg::PH_IDLE, default: '0};
		end else if (step_en) begin
			seq_q <= nxt;
		end
	end

endmodule

>>> sv/one_wire_temperature_reader.sv
// top level of the one-wire temperature reader: tick channel, result channel, config port
//
// channel   handshake                fields
// in        in_valid / in_stall      start_req, line_in
// out       out_valid / out_stall    drive_low, busy_res, done_res, device_missing, temperature
// config    psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// one tick is taken per clock while the result is not stalled; its result then moves into the output register
// a tick sits in the input register while the sequencer computes its result
// reset puts the sequencer idle with the default bus timings and a zero temperature
// a stalled result holds the output register; a new tick is still taken while the
// input register is free, further ticks wait until the result is taken
module one_wire_temperature_reader (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                start_req,
	input  logic                                line_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                drive_low,
	output logic                                busy_res,
	output logic                                done_res,
	output logic                                device_missing,
	output logic signed [15:0]                  temperature,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [owtr_pkg::CfgAddrWidth-1:0]   paddr,
	input  logic [owtr_pkg::CfgDataWidth-1:0]   pwdata,
	output logic [owtr_pkg::CfgDataWidth-1:0]   prdata,
	output logic                                pready
);

	owtr_pkg::cfg_t     cfg;
	owtr_pkg::result_t  res;
	owtr_pkg::result_t  res_q;
	logic               valid_s1;
	logic               start_s1;
	logic               line_s1;
	logic               out_valid_q;
	logic               adv;
	logic               in_take;

	owtr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	owtr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step_en (adv),
		.start   (start_s1),
		.line    (line_s1),
		.res     (res)
	);

	// the held tick moves on whenever the output register is free or being emptied
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			start_s1 <= start_req;
			line_s1  <= line_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign drive_low      = res_q.drive_low;
	assign busy_res       = res_q.busy;
	assign done_res       = res_q.done;
	assign device_missing = res_q.missing;
	assign temperature    = res_q.temperature;

	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!done_res || busy_res))
		else $error("done flagged outside a busy tick");

	a_drive_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!drive_low || busy_res))
		else $error("line driven low while idle");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with a free pipeline");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced tick produced no result");

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the one-wire temperature reader: tick stimulus, bus model, apb setup
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 100000;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic start_req;
	logic line_in;
	logic out_valid;
	logic out_stall;
	logic drive_low;
	logic busy_res;
	logic done_res;
	logic device_missing;
	logic signed [15:0] temperature;
	logic psel;
	logic penable;
	logic pwrite;
	logic [owtr_pkg::CfgAddrWidth-1:0] paddr;
	logic [owtr_pkg::CfgDataWidth-1:0] pwdata;
	logic [owtr_pkg::CfgDataWidth-1:0] prdata;
	logic pready;

	one_wire_temperature_reader DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.start_req      (start_req),
		.line_in        (line_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_low      (drive_low),
		.busy_res       (busy_res),
		.done_res       (done_res),
		.device_missing (device_missing),
		.temperature    (temperature),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bus sequencer model state
	owtr_pkg::phase_t ph;
	logic [19:0]      ticks;
	logic [2:0]       bit_pos;
	owtr_pkg::step_t  step_no;
	logic [7:0]       shreg;
	logic [7:0]       lo_byte;
	logic [15:0]      temp_reg;
	logic             absent;
	logic             seq_done;
	owtr_pkg::cfg_t   timing;

	owtr_pkg::result_t expected_bus_q[$];
	int      mismatches = 0;
	int      cycle_count = 0;
	logic    idle_en;
	logic    stall_en;
	logic    hold_off;

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s at %0t: expected %0h, got %0h", what, $time, want, got);
	endfunction

	function automatic logic [7:0] command_byte(input owtr_pkg::step_t k);
		logic [7:0] c;
		unique case (k)
			owtr_pkg::STEP_SKIP_ROM1, owtr_pkg::STEP_SKIP_ROM2: c = owtr_pkg::CMD_SKIP_ROM;
			owtr_pkg::STEP_CONVERT:                             c = owtr_pkg::CMD_CONVERT;
			owtr_pkg::STEP_READ_CMD:                            c = owtr_pkg::CMD_READ_SCRATCH;
			default:                                            c = 8'h00;
		endcase
		return c;
	endfunction

	// length of a phase in ticks; sampling phases last at least one tick
	function automatic logic [19:0] span(input owtr_pkg::phase_t p);
		logic [19:0] d;
		unique case (p)
			owtr_pkg::PH_R_PRE:   d = 20'(timing.short_slot);
			owtr_pkg::PH_R_LOW:   d = 20'(timing.reset_low);
			owtr_pkg::PH_R_WAIT:
				d = (timing.presence_sample == 8'd0) ? 20'd1 : 20'(timing.presence_sample);
			owtr_pkg::PH_R_REC:   d = 20'(timing.presence_recovery);
			owtr_pkg::PH_W_LOW:
				d = shreg[0] ? 20'(timing.short_slot) : 20'(timing.long_slot);
			owtr_pkg::PH_W_REL:
				d = shreg[0] ? 20'(timing.long_slot) : 20'(timing.short_slot);
			owtr_pkg::PH_CONV:    d = timing.convert_wait;
			owtr_pkg::PH_RD_LOW:  d = 20'(timing.short_slot);
			owtr_pkg::PH_RD_REL:
				d = (timing.read_sample == 4'd0) ? 20'd1 : 20'(timing.read_sample);
			owtr_pkg::PH_RD_TAIL: d = 20'(timing.read_tail);
			default:              d = 20'd1;
		endcase
		return d;
	endfunction

	function automatic owtr_pkg::phase_t wrap_up();
		seq_done = 1'b1;
		step_no = owtr_pkg::STEP_RESET1;
		bit_pos = 3'd0;
		return owtr_pkg::PH_IDLE;
	endfunction

	function automatic owtr_pkg::phase_t begin_step(input owtr_pkg::step_t k);
		owtr_pkg::phase_t nxt;
		step_no = k;
		bit_pos = 3'd0;
		unique case (k)
			owtr_pkg::STEP_CONV_WAIT: nxt = owtr_pkg::PH_CONV;
			owtr_pkg::STEP_RESET2:    nxt = owtr_pkg::PH_R_PRE;
			owtr_pkg::STEP_READ_LO, owtr_pkg::STEP_READ_HI: begin
				shreg = 8'd0;
				nxt = owtr_pkg::PH_RD_LOW;
			end
			default: begin
				shreg = command_byte(k);
				nxt = owtr_pkg::PH_W_LOW;
			end
		endcase
		return nxt;
	endfunction

	// what happens when phase p runs out; line is the level on its last tick
	function automatic owtr_pkg::phase_t advance(input owtr_pkg::phase_t p, input logic line);
		owtr_pkg::phase_t nxt;
		unique case (p)
			owtr_pkg::PH_R_PRE: nxt = owtr_pkg::PH_R_LOW;
			owtr_pkg::PH_R_LOW: nxt = owtr_pkg::PH_R_WAIT;
			owtr_pkg::PH_R_WAIT: begin
				if (step_no == owtr_pkg::STEP_RESET1)
					absent = line;
				nxt = owtr_pkg::PH_R_REC;
			end
			owtr_pkg::PH_R_REC: begin
				if (step_no != owtr_pkg::STEP_RESET1)
					nxt = begin_step(owtr_pkg::STEP_SKIP_ROM2);
				else if (absent)
					nxt = wrap_up();
				else
					nxt = begin_step(owtr_pkg::STEP_SKIP_ROM1);
			end
			owtr_pkg::PH_W_LOW: nxt = owtr_pkg::PH_W_REL;
			owtr_pkg::PH_W_REL: begin
				shreg = shreg >> 1;
				if (bit_pos >= owtr_pkg::LAST_BIT) begin
					nxt = begin_step(step_no + 3'd1);
				end else begin
					bit_pos = bit_pos + 3'd1;
					nxt = owtr_pkg::PH_W_LOW;
				end
			end
			owtr_pkg::PH_CONV:   nxt = begin_step(owtr_pkg::STEP_RESET2);
			owtr_pkg::PH_RD_LOW: nxt = owtr_pkg::PH_RD_REL;
			owtr_pkg::PH_RD_REL: begin
				shreg = {line, shreg[7:1]};
				nxt = owtr_pkg::PH_RD_TAIL;
			end
			owtr_pkg::PH_RD_TAIL: begin
				if (bit_pos < owtr_pkg::LAST_BIT) begin
					bit_pos = bit_pos + 3'd1;
					nxt = owtr_pkg::PH_RD_LOW;
				end else if (step_no == owtr_pkg::STEP_READ_LO) begin
					lo_byte = shreg;
					nxt = begin_step(owtr_pkg::STEP_READ_HI);
				end else begin
					temp_reg = {shreg, lo_byte};
					nxt = wrap_up();
				end
			end
			default: nxt = wrap_up();
		endcase
		return nxt;
	endfunction

	// zero-length phases that do not sample are passed through at once
	function automatic void move_to(input owtr_pkg::phase_t p);
		ph = p;
		ticks = 20'd0;
		while (ph != owtr_pkg::PH_IDLE && span(ph) == 20'd0) begin
			ph = advance(ph, 1'b0);
			ticks = 20'd0;
		end
	endfunction

	function automatic owtr_pkg::result_t bus_tick(input logic start, input logic line);
		owtr_pkg::result_t r;
		seq_done = 1'b0;
		if (ph == owtr_pkg::PH_IDLE && start) begin
			absent = 1'b0;
			step_no = owtr_pkg::STEP_RESET1;
			bit_pos = 3'd0;
			move_to(owtr_pkg::PH_R_PRE);
		end
		r.drive_low = 1'b0;
		r.busy = 1'b0;
		if (ph != owtr_pkg::PH_IDLE) begin
			r.busy = 1'b1;
			r.drive_low = (ph == owtr_pkg::PH_R_LOW || ph == owtr_pkg::PH_W_LOW ||
				ph == owtr_pkg::PH_RD_LOW);
			ticks = ticks + 20'd1;
			if (ticks >= span(ph))
				move_to(advance(ph, line));
		end
		r.done = seq_done;
		r.missing = absent;
		r.temperature = temp_reg;
		return r;
	endfunction

	// level a responding sensor would put on the line during the coming tick
	function automatic logic sensor_level(input logic present, input logic [15:0] scratch,
			input int noise_pct);
		logic lvl;
		unique case (ph)
			owtr_pkg::PH_R_WAIT: lvl = !present;
			owtr_pkg::PH_RD_REL: lvl = scratch[{step_no == owtr_pkg::STEP_READ_HI, bit_pos}];
			default:             lvl = 1'b1;
		endcase
		if ($urandom_range(0, 99) < noise_pct)
			lvl = 1'($urandom_range(0, 1));
		return lvl;
	endfunction

	function automatic logic [31:0] reg_mask(input owtr_pkg::reg_idx_t idx);
		logic [31:0] m;
		unique case (idx)
			owtr_pkg::REG_RESET_LOW, owtr_pkg::REG_PRESENCE_RECOVERY: m = 32'h0000_FFFF;
			owtr_pkg::REG_PRESENCE_SAMPLE, owtr_pkg::REG_LONG_SLOT, owtr_pkg::REG_READ_TAIL:
				m = 32'h0000_00FF;
			owtr_pkg::REG_SHORT_SLOT, owtr_pkg::REG_READ_SAMPLE: m = 32'h0000_000F;
			default: m = 32'h000F_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] reg_value(input owtr_pkg::reg_idx_t idx);
		logic [31:0] v;
		unique case (idx)
			owtr_pkg::REG_RESET_LOW:         v = 32'(timing.reset_low);
			owtr_pkg::REG_PRESENCE_SAMPLE:   v = 32'(timing.presence_sample);
			owtr_pkg::REG_PRESENCE_RECOVERY: v = 32'(timing.presence_recovery);
			owtr_pkg::REG_SHORT_SLOT:        v = 32'(timing.short_slot);
			owtr_pkg::REG_LONG_SLOT:         v = 32'(timing.long_slot);
			owtr_pkg::REG_READ_SAMPLE:       v = 32'(timing.read_sample);
			owtr_pkg::REG_READ_TAIL:         v = 32'(timing.read_tail);
			default:                         v = 32'(timing.convert_wait);
		endcase
		return v;
	endfunction

	function automatic int pick(input int lo, input int hi, input int ext);
		return ($urandom_range(0, 3) == 0) ? ext : int'($urandom_range(lo, hi));
	endfunction

	// garbage above the register width must be dropped by the block
	task automatic write_reg(input owtr_pkg::reg_idx_t idx, input logic [31:0] val);
		logic [31:0] mask;
		mask = reg_mask(idx);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= (val & mask) | ($urandom() & ~mask);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		unique case (idx)
			owtr_pkg::REG_RESET_LOW:         timing.reset_low = val[15:0];
			owtr_pkg::REG_PRESENCE_SAMPLE:   timing.presence_sample = val[7:0];
			owtr_pkg::REG_PRESENCE_RECOVERY: timing.presence_recovery = val[15:0];
			owtr_pkg::REG_SHORT_SLOT:        timing.short_slot = val[3:0];
			owtr_pkg::REG_LONG_SLOT:         timing.long_slot = val[7:0];
			owtr_pkg::REG_READ_SAMPLE:       timing.read_sample = val[3:0];
			owtr_pkg::REG_READ_TAIL:         timing.read_tail = val[7:0];
			default:                         timing.convert_wait = val[19:0];
		endcase
	endtask

	task automatic read_reg(input owtr_pkg::reg_idx_t idx);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== reg_value(idx))
			flag_mismatch("register readback", reg_value(idx), prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_timing(input owtr_pkg::cfg_t c);
		write_reg(owtr_pkg::REG_RESET_LOW, 32'(c.reset_low));
		write_reg(owtr_pkg::REG_PRESENCE_SAMPLE, 32'(c.presence_sample));
		write_reg(owtr_pkg::REG_PRESENCE_RECOVERY, 32'(c.presence_recovery));
		write_reg(owtr_pkg::REG_SHORT_SLOT, 32'(c.short_slot));
		write_reg(owtr_pkg::REG_LONG_SLOT, 32'(c.long_slot));
		write_reg(owtr_pkg::REG_READ_SAMPLE, 32'(c.read_sample));
		write_reg(owtr_pkg::REG_READ_TAIL, 32'(c.read_tail));
		write_reg(owtr_pkg::REG_CONVERT_WAIT, 32'(c.convert_wait));
	endtask

	task automatic send_tick(input logic start, input logic line);
		int gap;
		gap = idle_en ? int'($urandom_range(0, 5)) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		start_req <= start;
		line_in <= line;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_bus_q.push_back(bus_tick(start, line));
	endtask

	// let every expected result drain before touching the registers
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bus_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_sequence(input logic present, input logic [15:0] scratch,
			input logic hold_start);
		send_tick(1'b1, sensor_level(present, scratch, 0));
		while (!seq_done)
			send_tick(hold_start, sensor_level(present, scratch, 0));
	endtask

	task automatic test_register_access();
		for (int i = 0; i < 8; i++)
			read_reg(owtr_pkg::reg_idx_t'(i));
		for (int i = 0; i < 8; i++) begin
			write_reg(owtr_pkg::reg_idx_t'(i), 32'hFFFF_FFFF);
			read_reg(owtr_pkg::reg_idx_t'(i));
			write_reg(owtr_pkg::reg_idx_t'(i), 32'h0);
			read_reg(owtr_pkg::reg_idx_t'(i));
			write_reg(owtr_pkg::reg_idx_t'(i), $urandom());
			read_reg(owtr_pkg::reg_idx_t'(i));
		end
		write_reg(owtr_pkg::REG_RESET_LOW, 32'(owtr_pkg::RST_RESET_LOW));
		write_reg(owtr_pkg::REG_PRESENCE_SAMPLE, 32'(owtr_pkg::RST_PRESENCE_SAMPLE));
		write_reg(owtr_pkg::REG_PRESENCE_RECOVERY, 32'(owtr_pkg::RST_PRESENCE_RECOVERY));
		write_reg(owtr_pkg::REG_SHORT_SLOT, 32'(owtr_pkg::RST_SHORT_SLOT));
		write_reg(owtr_pkg::REG_LONG_SLOT, 32'(owtr_pkg::RST_LONG_SLOT));
		write_reg(owtr_pkg::REG_READ_SAMPLE, 32'(owtr_pkg::RST_READ_SAMPLE));
		write_reg(owtr_pkg::REG_READ_TAIL, 32'(owtr_pkg::RST_READ_TAIL));
		write_reg(owtr_pkg::REG_CONVERT_WAIT, 32'(owtr_pkg::RST_CONVERT_WAIT));
	endtask

	task automatic test_idle_ticks();
		for (int i = 0; i < 24; i++)
			send_tick(1'b0, 1'($urandom_range(0, 1)));
		settle();
	endtask

	// zero-length slots everywhere, so whole command bytes pass in no time
	task automatic test_temperature_extremes();
		owtr_pkg::cfg_t c;
		logic [15:0] values[8];
		c.reset_low = 16'd2;
		c.presence_sample = 8'd0;
		c.presence_recovery = 16'd0;
		c.short_slot = 4'd0;
		c.long_slot = 8'd0;
		c.read_sample = 4'd0;
		c.read_tail = 8'd0;
		c.convert_wait = 20'd0;
		load_timing(c);
		values = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
			16'h0550, 16'hFC90, 16'hAAAA, 16'h5555};
		foreach (values[i])
			run_sequence(1'b1, values[i], i[0]);
		settle();
	endtask

	task automatic test_missing_device();
		owtr_pkg::cfg_t c;
		c.reset_low = 16'd3;
		c.presence_sample = 8'd2;
		c.presence_recovery = 16'd1;
		c.short_slot = 4'd1;
		c.long_slot = 8'd2;
		c.read_sample = 4'd1;
		c.read_tail = 8'd1;
		c.convert_wait = 20'd2;
		load_timing(c);
		run_sequence(1'b1, 16'h1234, 1'b0);
		// temperature must survive a sequence with no presence pulse
		run_sequence(1'b0, 16'h0BAD, 1'b0);
		run_sequence(1'b1, 16'hFE6F, 1'b0);
		settle();
	endtask

	task automatic test_backpressure();
		idle_en = 1'b0;
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
		join_none
		run_sequence(1'b1, 16'h0191, 1'b0);
		settle();
		idle_en = 1'b1;
	endtask

	// widest values in most registers (not reset_low or presence_recovery), no device so only the first reset runs
	task automatic test_long_timings();
		owtr_pkg::cfg_t c;
		idle_en = 1'b0;
		stall_en = 1'b0;
		c.reset_low = 16'd150;
		c.presence_sample = 8'd255;
		c.presence_recovery = 16'd20;
		c.short_slot = 4'd15;
		c.long_slot = 8'd255;
		c.read_sample = 4'd15;
		c.read_tail = 8'd255;
		c.convert_wait = 20'hF_FFFF;
		load_timing(c);
		run_sequence(1'b0, 16'h0000, 1'b0);
		settle();
		idle_en = 1'b1;
		stall_en = 1'b1;
	endtask

	// mostly clean sensor replies with random content, some line noise and stray starts
	task automatic test_random_traffic();
		owtr_pkg::cfg_t c;
		logic present;
		logic [15:0] scratch;
		int n;
		for (int round = 0; round < 3; round++) begin
			c.reset_low = 16'($urandom_range(1, 6));
			c.presence_sample = 8'(pick(1, 4, 0));
			c.presence_recovery = 16'(pick(0, 3, 0));
			c.short_slot = 4'($urandom_range(0, 2));
			c.long_slot = 8'(pick(1, 3, 0));
			c.read_sample = 4'(pick(1, 3, 0));
			c.read_tail = 8'(pick(0, 3, 0));
			c.convert_wait = 20'(pick(0, 6, 0));
			load_timing(c);
			idle_en = (round != 1);
			stall_en = (round != 2);
			present = ($urandom_range(0, 99) < 85);
			scratch = 16'($urandom());
			n = 0;
			while (n < 60 || ph != owtr_pkg::PH_IDLE) begin
				send_tick(n < 60 && $urandom_range(0, 7) == 0,
					sensor_level(present, scratch, 8));
				n++;
				if (seq_done) begin
					present = ($urandom_range(0, 99) < 85);
					scratch = 16'($urandom());
				end
			end
			settle();
		end
		idle_en = 1'b1;
		stall_en = 1'b1;
	endtask

	// result side: per-transaction stall draw, long hold-off on request
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= hold_off || (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
			@(posedge clk);
			if (out_valid && !out_stall && stall_en)
				stall_left = int'($urandom_range(0, 5));
		end
	end

	always @(posedge clk) begin : result_check
		owtr_pkg::result_t want;
		if (out_valid && !out_stall) begin
			if (expected_bus_q.size() == 0) begin
				flag_mismatch("unexpected transaction", 32'h0, 32'h1);
			end else begin
				want = expected_bus_q.pop_front();
				if (drive_low !== want.drive_low)
					flag_mismatch("drive_low", 32'(want.drive_low), 32'(drive_low));
				if (busy_res !== want.busy)
					flag_mismatch("busy_res", 32'(want.busy), 32'(busy_res));
				if (done_res !== want.done)
					flag_mismatch("done_res", 32'(want.done), 32'(done_res));
				if (device_missing !== want.missing)
					flag_mismatch("device_missing", 32'(want.missing), 32'(device_missing));
				if (temperature !== want.temperature)
					flag_mismatch("temperature", 32'(want.temperature), 32'(temperature));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		start_req = 1'b0;
		line_in = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_en = 1'b1;
		stall_en = 1'b1;
		hold_off = 1'b0;
		timing.reset_low = owtr_pkg::RST_RESET_LOW;
		timing.presence_sample = owtr_pkg::RST_PRESENCE_SAMPLE;
		timing.presence_recovery = owtr_pkg::RST_PRESENCE_RECOVERY;
		timing.short_slot = owtr_pkg::RST_SHORT_SLOT;
		timing.long_slot = owtr_pkg::RST_LONG_SLOT;
		timing.read_sample = owtr_pkg::RST_READ_SAMPLE;
		timing.read_tail = owtr_pkg::RST_READ_TAIL;
		timing.convert_wait = owtr_pkg::RST_CONVERT_WAIT;
		ph = owtr_pkg::PH_IDLE;
		ticks = 20'd0;
		bit_pos = 3'd0;
		step_no = owtr_pkg::STEP_RESET1;
		shreg = 8'd0;
		lo_byte = 8'd0;
		temp_reg = 16'd0;
		absent = 1'b0;
		seq_done = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_access();
		test_idle_ticks();
		test_temperature_extremes();
		test_missing_device();
		test_backpressure();
		test_long_timings();
		test_random_traffic();

		settle();
		repeat (10) @(posedge clk);
		if (expected_bus_q.size() != 0)
			flag_mismatch("results still outstanding", 32'h0, 32'(expected_bus_q.size()));
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
